@@ design/tetb_pkg.sv @@
// ----------------------------------------------------------------------------
// tetb_pkg
// Shared types and constants for the triangle edge test with barycentric weights.
// ----------------------------------------------------------------------------
package tetb_pkg;

    // output weight format
    localparam int WEIGHT_W = 24;
    typedef logic signed [WEIGHT_W-1:0] t_weight;

    localparam t_weight WEIGHT_MAX = t_weight'(24'sh7FFFFF);
    localparam t_weight WEIGHT_MIN = t_weight'(24'sh800000);

    // quotient bits produced by the divider: floor(num * 2^(FRAC_BITS+1) / den), saturating above
    localparam int QUOT_BITS = 26;

endpackage

@@ design/tetb_if.sv @@
// ----------------------------------------------------------------------------
// tetb_pix_if / tetb_res_if
// Valid/ready channels: triangle + pixel items in, coverage + weight items out.
// ----------------------------------------------------------------------------
interface tetb_pix_if #(parameter int COORD_BITS = 12) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] v0_x;
    logic [COORD_BITS-1:0] v0_y;
    logic [COORD_BITS-1:0] v1_x;
    logic [COORD_BITS-1:0] v1_y;
    logic [COORD_BITS-1:0] v2_x;
    logic [COORD_BITS-1:0] v2_y;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, pixel_x, pixel_y,
                    input ready);
    modport sink   (input valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, pixel_x, pixel_y,
                    output ready);
endinterface

interface tetb_res_if ();
    logic                         valid;
    logic                         ready;
    logic                         inside_res;
    logic                         degenerate;
    logic signed [23:0]           weight_a;
    logic signed [23:0]           weight_b;
    logic signed [23:0]           weight_c;

    modport source (output valid, inside_res, degenerate, weight_a, weight_b, weight_c,
                    input ready);
    modport sink   (input valid, inside_res, degenerate, weight_a, weight_b, weight_c,
                    output ready);
endinterface

@@ design/tetb_div.sv @@
// ----------------------------------------------------------------------------
// tetb_div
// Pipelined restoring divider: round(num * 2^FRAC_BITS / den), signed, saturated.
// Entry stage, one quotient bit per stage, then a rounding stage; all advance on i_en.
// ----------------------------------------------------------------------------
module tetb_div #(
    parameter int XW        = 27,
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [XW-1:0]          i_num,
    input  logic [XW-1:0]          i_den,
    input  logic                   i_neg,
    output tetb_pkg::t_weight      o_weight
);
    import tetb_pkg::*;

    localparam int RW = XW + QUOT_BITS;
    localparam int QW = QUOT_BITS + 1;

    logic [RW-1:0]        r_rem [QUOT_BITS+1];
    logic [XW-1:0]        r_den [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] r_quo [QUOT_BITS+1];
    logic                 r_neg [QUOT_BITS+1];
    logic                 r_sat [QUOT_BITS+1];
    t_weight              r_weight;

    logic [RW-1:0] w_num2;
    logic [RW-1:0] w_den_top;

    // entry stage: scale numerator by 2^(F+1), flag quotients that overflow
    assign w_num2    = RW'(i_num) << (FRAC_BITS + 1);
    assign w_den_top = RW'(i_den) << QUOT_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_num2;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_neg[0] <= i_neg;
            r_sat[0] <= (w_num2 >= w_den_top);
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 1; j <= QUOT_BITS; j++) begin : g_stage
        logic [RW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = RW'(r_den[j-1]) << (QUOT_BITS - j);
        assign w_ge = (r_rem[j-1] >= w_sh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? (r_rem[j-1] - w_sh) : r_rem[j-1];
                r_den[j] <= r_den[j-1];
                r_quo[j] <= r_quo[j-1] | (QUOT_BITS'(w_ge) << (QUOT_BITS - j));
                r_neg[j] <= r_neg[j-1];
                r_sat[j] <= r_sat[j-1];
            end
        end
    end

    // round half away from zero, apply sign, clamp
    logic [QW-1:0] w_q;
    t_weight       n_weight;
    assign w_q = (QW'(r_quo[QUOT_BITS]) + QW'(1)) >> 1;

    always_comb begin
        if (r_neg[QUOT_BITS]) begin
            if (r_sat[QUOT_BITS] || (w_q > QW'(2**(WEIGHT_W-1))))
                n_weight = WEIGHT_MIN;
            else
                n_weight = t_weight'(-$signed({1'b0, w_q}));
        end else begin
            if (r_sat[QUOT_BITS] || (w_q > QW'(2**(WEIGHT_W-1) - 1)))
                n_weight = WEIGHT_MAX;
            else
                n_weight = t_weight'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_weight <= n_weight;
        end
    end

    assign o_weight = r_weight;

endmodule

@@ design/triangle_edge_test_barycentric.sv @@
// ----------------------------------------------------------------------------
// triangle_edge_test_barycentric
// Edge-function point-in-triangle test, top-left fill rule, barycentric weights.
// ----------------------------------------------------------------------------
// Channel  | Dir | Payload
// i_pix    | in  | v0..v2 x/y, pixel_x/y (COORD_BITS each, unsigned)
// o_res    | out | inside_res, degenerate, weight_a/b/c (24b signed, FRAC_BITS frac)
//
// One item per cycle while o_res is not stalled; edge, product and sum stages,
// then the divider: one entry stage, one stage per quotient bit, one rounding stage.
// Synchronous active-low reset clears the valid bits only.
// A stall on o_res freezes the whole pipe; i_pix.ready drops while the
// last stage holds an item that is not taken.
// ----------------------------------------------------------------------------
module triangle_edge_test_barycentric #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tetb_pix_if.sink    i_pix,
    tetb_res_if.source  o_res
);
    import tetb_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int XW  = PW + 1;
    localparam int LAT = QUOT_BITS + 2;
    localparam int NST = 3 + LAT;

    logic           r_vld [NST];
    logic           w_en;

    assign w_en        = !r_vld[NST-1] || o_res.ready;
    assign i_pix.ready = w_en;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_pix.valid;
            for (int k = 1; k < NST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    function automatic logic signed [DW-1:0] diff(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
        diff = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    logic [COORD_BITS-1:0] w_vx [3];
    logic [COORD_BITS-1:0] w_vy [3];
    assign w_vx[0] = i_pix.v0_x;
    assign w_vy[0] = i_pix.v0_y;
    assign w_vx[1] = i_pix.v1_x;
    assign w_vy[1] = i_pix.v1_y;
    assign w_vx[2] = i_pix.v2_x;
    assign w_vy[2] = i_pix.v2_y;

    // stage 1: edge vectors, pixel offsets, second area leg
    logic signed [DW-1:0] r_ex [3];
    logic signed [DW-1:0] r_ey [3];
    logic signed [DW-1:0] r_dx [3];
    logic signed [DW-1:0] r_dy [3];
    logic signed [DW-1:0] r_ax;
    logic signed [DW-1:0] r_ay;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_ex[i] <= diff(w_vx[(i+1)%3], w_vx[i]);
                r_ey[i] <= diff(w_vy[(i+1)%3], w_vy[i]);
                r_dx[i] <= diff(i_pix.pixel_x, w_vx[i]);
                r_dy[i] <= diff(i_pix.pixel_y, w_vy[i]);
            end
            r_ax <= diff(w_vx[2], w_vx[0]);
            r_ay <= diff(w_vy[2], w_vy[0]);
        end
    end

    // stage 2: cross-product terms, top/left edge flags
    logic signed [PW-1:0] r_pa [3];
    logic signed [PW-1:0] r_pb [3];
    logic signed [PW-1:0] r_sa;
    logic signed [PW-1:0] r_sb;
    logic                 r_tl [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= PW'(r_ex[i]) * PW'(r_dy[i]);
                r_pb[i] <= PW'(r_ey[i]) * PW'(r_dx[i]);
                r_tl[i] <= (r_ey[i] > 0) || ((r_ey[i] == 0) && (r_ex[i] > 0));
            end
            r_sa <= PW'(r_ex[0]) * PW'(r_ay);
            r_sb <= PW'(r_ey[0]) * PW'(r_ax);
        end
    end

    // stage 3: edge values and area, coverage, sign/magnitude split
    logic signed [XW-1:0] w_w [3];
    logic signed [XW-1:0] w_s;
    logic                 n_inside;
    logic [XW-1:0]        r_wmag [3];
    logic                 r_wneg [3];
    logic [XW-1:0]        r_smag;
    logic                 r_sneg;
    logic                 r_inside;
    logic                 r_degen;

    always_comb begin
        n_inside = 1'b1;
        for (int i = 0; i < 3; i++) begin
            w_w[i] = XW'(r_pa[i]) - XW'(r_pb[i]);
            if (!((w_w[i] > 0) || ((w_w[i] == 0) && r_tl[i]))) n_inside = 1'b0;
        end
        w_s = XW'(r_sa) - XW'(r_sb);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_wmag[i] <= w_w[i][XW-1] ? XW'(-w_w[i]) : XW'(w_w[i]);
                r_wneg[i] <= w_w[i][XW-1];
            end
            r_smag   <= w_s[XW-1] ? XW'(-w_s) : XW'(w_s);
            r_sneg   <= w_s[XW-1];
            r_inside <= n_inside;
            r_degen  <= (w_s == 0);
        end
    end

    // dividers: edge i's weight goes to the opposite vertex
    t_weight w_wa, w_wb, w_wc;

    tetb_div #(.XW(XW), .FRAC_BITS(FRAC_BITS)) u_div_a (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_wmag[1]), .i_den(r_smag),
        .i_neg(r_wneg[1] ^ r_sneg), .o_weight(w_wa));
    tetb_div #(.XW(XW), .FRAC_BITS(FRAC_BITS)) u_div_b (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_wmag[2]), .i_den(r_smag),
        .i_neg(r_wneg[2] ^ r_sneg), .o_weight(w_wb));
    tetb_div #(.XW(XW), .FRAC_BITS(FRAC_BITS)) u_div_c (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_wmag[0]), .i_den(r_smag),
        .i_neg(r_wneg[0] ^ r_sneg), .o_weight(w_wc));

    // flags ride alongside the divider
    logic r_ins_d [LAT];
    logic r_dgn_d [LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ins_d[0] <= r_inside;
            r_dgn_d[0] <= r_degen;
            for (int k = 1; k < LAT; k++) begin
                r_ins_d[k] <= r_ins_d[k-1];
                r_dgn_d[k] <= r_dgn_d[k-1];
            end
        end
    end

    // result: a zero-area triangle forces outside and zero weights
    assign o_res.valid      = r_vld[NST-1];
    assign o_res.degenerate = r_dgn_d[LAT-1];
    assign o_res.inside_res = r_ins_d[LAT-1] && !r_dgn_d[LAT-1];
    assign o_res.weight_a   = r_dgn_d[LAT-1] ? '0 : w_wa;
    assign o_res.weight_b   = r_dgn_d[LAT-1] ? '0 : w_wb;
    assign o_res.weight_c   = r_dgn_d[LAT-1] ? '0 : w_wc;

endmodule

@@ design/tetb_chk.sv @@
// ----------------------------------------------------------------------------
// tetb_chk
// Port-level checks for the triangle edge test, bound to the top level.
// ----------------------------------------------------------------------------
module tetb_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_inside,
    input logic               i_degen,
    input logic signed [23:0] i_wa,
    input logic signed [23:0] i_wb,
    input logic signed [23:0] i_wc
);
    import tetb_pkg::*;

    // a stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_inside)
            && $stable(i_degen) && $stable(i_wa) && $stable(i_wb) && $stable(i_wc))
        else $error("stalled result item changed");

    // zero-area triangle: outside, zero weights
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degen |-> !i_inside && i_wa == 0 && i_wb == 0 && i_wc == 0)
        else $error("degenerate item with nonzero result");

    // a covered pixel has no negative weight
    a_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_inside |-> !i_wa[23] && !i_wb[23] && !i_wc[23])
        else $error("covered pixel with negative weight");

    // input side only stalls while a result waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

endmodule

bind triangle_edge_test_barycentric tetb_chk u_tetb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_inside    (o_res.inside_res),
    .i_degen     (o_res.degenerate),
    .i_wa        (o_res.weight_a),
    .i_wb        (o_res.weight_b),
    .i_wc        (o_res.weight_c)
);

@@ tb/sv/tb_triangle_edge_test_barycentric.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_edge_test_barycentric
// Feeds triangle + pixel items through the edge test, computes the expected
// coverage flag and barycentric weights for each item, and checks every
// result item in order. Random gaps and stalls on both channels, plus one
// long receiver hold-off so the pipe fills and the input stalls.
// ----------------------------------------------------------------------------
module tb_triangle_edge_test_barycentric;
    import tetb_pkg::*;

    localparam int CB = 12;
    localparam int FB = 16;
    localparam int N_RANDOM = 1730;
    localparam int IDLE_LIMIT = 20000;
    localparam int LATENCY = QUOT_BITS + 5;

    typedef struct packed {
        logic [CB-1:0] v0x, v0y, v1x, v1y, v2x, v2y, px, py;
    } t_tri_pix;

    typedef struct packed {
        logic    covered;
        logic    degen;
        t_weight wa, wb, wc;
    } t_coverage;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tetb_pix_if #(.COORD_BITS(CB)) pix_ch ();
    tetb_res_if res_ch ();

    triangle_edge_test_barycentric #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_tri_pix  pending_items[$];
    t_coverage expected_cov[$];
    int        n_errors = 0;
    int        n_results = 0;
    int        n_inside = 0;
    int        n_degen = 0;
    int        n_sat = 0;
    int        idle_cycles = 0;
    bit        stim_done = 1'b0;
    bit        hold_off = 1'b0;
    int        send_gap = 0;
    int        recv_gap = 0;

    // rounded, saturated fixed-point quotient w * 2^FB / s
    function automatic t_weight bary_weight(longint w, longint s);
        longint unsigned num, den, q;
        bit neg;
        num = (w < 0 ? -w : w) << FB;
        den = (s < 0 ? -s : s);
        q = (2 * num + den) / (2 * den);
        neg = (w < 0) != (s < 0);
        if (neg) return (q > 64'd8388608) ? WEIGHT_MIN : t_weight'(-longint'(q));
        return (q > 64'd8388607) ? WEIGHT_MAX : t_weight'(q);
    endfunction

    // top-left rule on one edge
    function automatic bit edge_covers(longint w, longint ex, longint ey);
        if (w == 0) return ey > 0 || (ey == 0 && ex > 0);
        return w > 0;
    endfunction

    function automatic t_coverage predict_coverage(t_tri_pix it);
        longint vx[3], vy[3], ex[3], ey[3], w[3], s;
        t_coverage c;
        bit in_all;
        vx[0] = it.v0x; vy[0] = it.v0y;
        vx[1] = it.v1x; vy[1] = it.v1y;
        vx[2] = it.v2x; vy[2] = it.v2y;
        in_all = 1'b1;
        for (int i = 0; i < 3; i++) begin
            ex[i] = vx[(i + 1) % 3] - vx[i];
            ey[i] = vy[(i + 1) % 3] - vy[i];
        end
        s = ex[0] * (vy[2] - vy[0]) - ey[0] * (vx[2] - vx[0]);
        for (int i = 0; i < 3; i++) begin
            w[i] = ex[i] * (longint'(it.py) - vy[i]) - ey[i] * (longint'(it.px) - vx[i]);
            if (!edge_covers(w[i], ex[i], ey[i])) in_all = 1'b0;
        end
        c = '0;
        if (s == 0) begin
            c.degen = 1'b1;
            return c;
        end
        c.covered = in_all;
        c.wa = bary_weight(w[1], s);
        c.wb = bary_weight(w[2], s);
        c.wc = bary_weight(w[0], s);
        return c;
    endfunction

    function automatic logic [CB-1:0] rnd_coord();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return CB'($urandom_range(0, 3));
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic int rnd_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_item(t_tri_pix it);
        pending_items.push_back(it);
    endtask

    // stimulus
    initial begin
        t_tri_pix it;
        logic [CB-1:0] m;
        m = '1;
        // ccw triangle (positive area), interior, vertex, top and left edges, hypotenuse, outside
        add_item('{0, 0, 100, 0, 0, 100, 10, 10});
        add_item('{0, 0, 100, 0, 0, 100, 0, 0});
        add_item('{0, 0, 100, 0, 0, 100, 50, 0});
        add_item('{0, 0, 100, 0, 0, 100, 0, 50});
        add_item('{0, 0, 100, 0, 0, 100, 50, 50});
        add_item('{0, 0, 100, 0, 0, 100, 60, 60});
        // clockwise (negative area) always outside
        add_item('{0, 0, 0, 100, 100, 0, 10, 10});
        // degenerate: collinear and all same point
        add_item('{0, 0, 10, 10, 20, 20, 5, 5});
        add_item('{7, 7, 7, 7, 7, 7, 7, 7});
        // extremes, huge weights that saturate
        add_item('{0, 0, 1, 0, 0, 1, m, m});
        add_item('{0, 0, 1, 0, 0, 1, 0, m});
        add_item('{0, 0, m, 0, 0, m, m, m});
        add_item('{m, m, 0, m, m, 0, 0, 0});
        add_item('{0, 0, m, 0, 0, m, 0, 0});
        add_item('{m, m, m, m, m, m, m, m});
        add_item('{0, 0, 1, 0, 1, 1, 0, m});
        add_item('{m, 0, m, m, 0, m, 0, 0});
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                it = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                      rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
            end else begin
                // small triangle with a pixel nearby, in one case of five on vertex v1
                it.v0x = CB'($urandom); it.v0y = CB'($urandom);
                it.v1x = it.v0x + CB'($urandom_range(0, 40)) - CB'(20);
                it.v1y = it.v0y + CB'($urandom_range(0, 40)) - CB'(20);
                it.v2x = it.v0x + CB'($urandom_range(0, 40)) - CB'(20);
                it.v2y = it.v0y + CB'($urandom_range(0, 40)) - CB'(20);
                it.px = it.v0x + CB'($urandom_range(0, 40)) - CB'(20);
                it.py = it.v0y + CB'($urandom_range(0, 40)) - CB'(20);
                if ($urandom_range(0, 4) == 0) begin
                    it.px = it.v1x; it.py = it.v1y;
                end
            end
            add_item(it);
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else if (pix_ch.valid && !pix_ch.ready) begin
            // hold the offered item
        end else begin
            if (pix_ch.valid)
                expected_cov.push_back(predict_coverage({pix_ch.v0_x, pix_ch.v0_y,
                    pix_ch.v1_x, pix_ch.v1_y, pix_ch.v2_x, pix_ch.v2_y,
                    pix_ch.pixel_x, pix_ch.pixel_y}));
            if (send_gap > 0 || pending_items.size() == 0) begin
                pix_ch.valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
                if (pending_items.size() == 0 && !pix_ch.valid) stim_done <= 1'b1;
            end else begin
                t_tri_pix it;
                it = pending_items.pop_front();
                pix_ch.valid <= 1'b1;
                {pix_ch.v0_x, pix_ch.v0_y, pix_ch.v1_x, pix_ch.v1_y,
                 pix_ch.v2_x, pix_ch.v2_y, pix_ch.pixel_x, pix_ch.pixel_y} <= it;
                send_gap <= rnd_gap();
            end
        end
    end

    // long receiver hold-off once, early in the random part
    initial begin
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // receiver ready
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            res_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            res_ch.ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            res_ch.ready <= 1'b1;
            if (res_ch.valid && res_ch.ready) recv_gap <= rnd_gap();
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (res_ch.valid && res_ch.ready) begin
                t_coverage got, want;
                got = {res_ch.inside_res, res_ch.degenerate,
                       res_ch.weight_a, res_ch.weight_b, res_ch.weight_c};
                n_results <= n_results + 1;
                if (expected_cov.size() == 0) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < 10) $display("unexpected result item %h", got);
                end else begin
                    want = expected_cov.pop_front();
                    n_inside <= n_inside + want.covered;
                    n_degen <= n_degen + want.degen;
                    if (want.wa == WEIGHT_MAX || want.wa == WEIGHT_MIN) n_sat <= n_sat + 1;
                    if (got !== want) begin
                        n_errors <= n_errors + 1;
                        if (n_errors < 10) begin
                            $display("mismatch: exp in=%0b dg=%0b a=%0d b=%0d c=%0d",
                                want.covered, want.degen, want.wa, want.wb, want.wc);
                            $display("          got in=%0b dg=%0b a=%0d b=%0d c=%0d",
                                got.covered, got.degen, got.wa, got.wb, got.wc);
                        end
                    end
                end
            end
        end
    end

    // reset, end of run, watchdog
    initial begin
        pix_ch.valid = 1'b0;
        {pix_ch.v0_x, pix_ch.v0_y, pix_ch.v1_x, pix_ch.v1_y,
         pix_ch.v2_x, pix_ch.v2_y, pix_ch.pixel_x, pix_ch.pixel_y} = '0;
        res_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && expected_cov.size() == 0) && idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
            $display("** triangle_edge_test_barycentric: FAILED **");
        end else begin
            repeat (LATENCY + 10) @(posedge i_clk);
            $display("checked %0d result items: %0d covered, %0d degenerate, %0d saturated",
                     n_results, n_inside, n_degen, n_sat);
            if (n_errors == 0 && expected_cov.size() == 0)
                $display("** triangle_edge_test_barycentric: PASSED **");
            else begin
                $display("%0d mismatches", n_errors);
                $display("** triangle_edge_test_barycentric: FAILED **");
            end
        end
        $finish;
    end

endmodule
